### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL files; only lwc_queue includes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LWC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define LWC_ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) else $error(msg);

`endif

### src/lwc_pkg.sv
// ----------------------------------------------------------------------------
// lwc_pkg
// Types and constants shared by the line window clipper modules.
// ----------------------------------------------------------------------------
package lwc_pkg;

  localparam int COORD_BITS   = 16;
  localparam int DELTA_W      = COORD_BITS + 1;
  localparam int NUM_W        = COORD_BITS + 2;
  localparam int DEN_W        = COORD_BITS + 1;
  localparam int PROD_W       = 2 * NUM_W;
  localparam int DIVD_W       = DEN_W + COORD_BITS;
  localparam int FRONT_STAGES = 6;
  localparam int LERP_LAT     = COORD_BITS + 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_DW       = 32;
  localparam int PADDR_W      = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0]    delta_t;

  typedef enum logic [1:0] {
    RegLeft   = 2'd0,
    RegBottom = 2'd1,
    RegRight  = 2'd2,
    RegTop    = 2'd3
  } lwc_reg_e;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } lwc_in_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } lwc_out_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } lwc_win_t;

  // Exact ratio num/den with den > 0.
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } frac_t;

  // A classified segment handed from the front to the back.
  typedef struct packed {
    logic   vis;
    coord_t x0;
    coord_t y0;
    delta_t dx;
    delta_t dy;
    frac_t  u1;
    frac_t  u2;
  } lwc_job_t;

endpackage

### src/lwc_front.sv
// ----------------------------------------------------------------------------
// lwc_front
// Forms the boundary ratios of a segment and reduces them to the entry and
// exit parameters, with the reject decision, over six pipeline stages.
// ----------------------------------------------------------------------------
module lwc_front import lwc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lwc_in_t  in_data_i,
  input  lwc_win_t win_i,
  input  logic     q_full_i,
  output logic     push_o,
  output lwc_job_t job_o
);

  function automatic frac_t entry_frac(input delta_t d, input coord_t p,
                                       input coord_t lo, input coord_t hi);
    frac_t f;
    f.num = '0;
    f.den = DEN_W'(1);
    if (d > 0) begin
      f.num = NUM_W'(lo) - NUM_W'(p);
      f.den = DEN_W'(d);
    end else if (d < 0) begin
      f.num = NUM_W'(p) - NUM_W'(hi);
      f.den = DEN_W'(-d);
    end
    return f;
  endfunction

  function automatic frac_t exit_frac(input delta_t d, input coord_t p,
                                      input coord_t lo, input coord_t hi);
    frac_t f;
    f.num = NUM_W'(1);
    f.den = DEN_W'(1);
    if (d > 0) begin
      f.num = NUM_W'(hi) - NUM_W'(p);
      f.den = DEN_W'(d);
    end else if (d < 0) begin
      f.num = NUM_W'(p) - NUM_W'(lo);
      f.den = DEN_W'(-d);
    end
    return f;
  endfunction

  function automatic logic signed [NUM_W-1:0] den_s(input frac_t f);
    return $signed({1'b0, f.den});
  endfunction

  logic                    en;
  logic [FRONT_STAGES-1:0] v_q;

  lwc_job_t j1_q, j2_q, j3_q, j4_q, j5_q, j6_q;
  lwc_job_t j2_d, j4_d, j6_d;
  frac_t    ey1_q, ly1_q, ey2_q, ly2_q, ey3_q, ly3_q;
  logic signed [PROD_W-1:0] pa_q, pb_q, pc_q, pd_q, pu_q, pv_q;

  coord_t x1, y1, x2, y2;
  delta_t dx, dy;
  logic   rej_x, rej_y;
  frac_t  zero_f, one_f;

  assign en         = !(v_q[FRONT_STAGES-1] && q_full_i);
  assign in_stall_o = !en;
  assign push_o     = en && v_q[FRONT_STAGES-1];
  assign job_o      = j6_q;

  assign x1 = in_data_i.start_x;
  assign y1 = in_data_i.start_y;
  assign x2 = in_data_i.end_x;
  assign y2 = in_data_i.end_y;
  assign dx = DELTA_W'(x2) - DELTA_W'(x1);
  assign dy = DELTA_W'(y2) - DELTA_W'(y1);

  // A boundary parallel to the segment rejects it when the segment lies outside.
  assign rej_x = (dx == '0) && ((x1 < win_i.left) || (x1 > win_i.right));
  assign rej_y = (dy == '0) && ((y1 < win_i.bottom) || (y1 > win_i.top));

  assign zero_f = '{num: '0, den: DEN_W'(1)};
  assign one_f  = '{num: NUM_W'(1), den: DEN_W'(1)};

  always_comb begin
    // Fold in the initial entry of zero and exit of one.
    j2_d    = j1_q;
    j2_d.u1 = (j1_q.u1.num > 0) ? j1_q.u1 : zero_f;
    j2_d.u2 = (j1_q.u2.num < den_s(j1_q.u2)) ? j1_q.u2 : one_f;

    j4_d    = j3_q;
    j4_d.u1 = (pa_q > pb_q) ? j3_q.u1 : ey3_q;
    j4_d.u2 = (pc_q < pd_q) ? j3_q.u2 : ly3_q;

    j6_d     = j5_q;
    j6_d.vis = j5_q.vis && !(pu_q > pv_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[FRONT_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j1_q.vis <= !(rej_x || rej_y);
      j1_q.x0  <= x1;
      j1_q.y0  <= y1;
      j1_q.dx  <= dx;
      j1_q.dy  <= dy;
      j1_q.u1  <= entry_frac(dx, x1, win_i.left, win_i.right);
      j1_q.u2  <= exit_frac(dx, x1, win_i.left, win_i.right);
      ey1_q    <= entry_frac(dy, y1, win_i.bottom, win_i.top);
      ly1_q    <= exit_frac(dy, y1, win_i.bottom, win_i.top);

      j2_q  <= j2_d;
      ey2_q <= (ey1_q.num > 0) ? ey1_q : zero_f;
      ly2_q <= (ly1_q.num < den_s(ly1_q)) ? ly1_q : one_f;

      j3_q  <= j2_q;
      ey3_q <= ey2_q;
      ly3_q <= ly2_q;
      pa_q  <= j2_q.u1.num * den_s(ey2_q);
      pb_q  <= ey2_q.num * den_s(j2_q.u1);
      pc_q  <= j2_q.u2.num * den_s(ly2_q);
      pd_q  <= ly2_q.num * den_s(j2_q.u2);

      j4_q <= j4_d;

      j5_q <= j4_q;
      pu_q <= j4_q.u1.num * den_s(j4_q.u2);
      pv_q <= j4_q.u2.num * den_s(j4_q.u1);

      j6_q <= j6_d;
    end
  end

endmodule

### src/lwc_queue.sv
// ----------------------------------------------------------------------------
// lwc_queue
// Short first-in first-out queue of classified segments between the front
// and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lwc_queue import lwc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lwc_job_t job_i,
  input  logic     pop_i,
  output lwc_job_t job_o,
  output logic     full_o,
  output logic     empty_o
);

  lwc_job_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  `LWC_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
  `LWC_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && full_o && !pop_i), "push to full queue")
  `LWC_ASSERT(a_no_pop_empty, clk_i, rst_ni, !(pop_i && empty_o), "pop from empty queue")
  `LWC_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push_i && !pop_i, !empty_o, "push lost")

endmodule

### src/lwc_lerp.sv
// ----------------------------------------------------------------------------
// lwc_lerp
// Pipelined x0 + (num/den)*delta, truncated toward zero: one multiply
// stage, one restoring divide stage per quotient bit and a rounding stage.
// ----------------------------------------------------------------------------
module lwc_lerp import lwc_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  coord_t x0_i,
  input  delta_t delta_i,
  input  frac_t  frac_i,
  output coord_t res_o
);

  logic [DIVD_W-1:0]     rem_q [COORD_BITS+1];
  logic [COORD_BITS-1:0] quo_q [COORD_BITS+1];
  logic [DEN_W-1:0]      den_q [COORD_BITS+1];
  logic                  neg_q [COORD_BITS+1];
  coord_t                x0_q  [COORD_BITS+1];
  coord_t                res_q;

  delta_t                 dmag_full;
  logic [COORD_BITS-1:0]  dmag;
  logic [DEN_W-1:0]       nmag;
  logic                   rem_nz;
  logic signed [NUM_W-1:0] flo, sum;

  assign dmag_full = delta_i[DELTA_W-1] ? -delta_i : delta_i;
  assign dmag      = dmag_full[COORD_BITS-1:0];
  assign nmag      = frac_i.num[DEN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DIVD_W'(nmag) * DIVD_W'(dmag);
      quo_q[0] <= '0;
      den_q[0] <= frac_i.den;
      neg_q[0] <= delta_i[DELTA_W-1];
      x0_q[0]  <= x0_i;
    end
  end

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_div
    localparam int Sh = COORD_BITS - 1 - k;
    logic [DIVD_W-1:0] trial;
    logic              take;

    assign trial = DIVD_W'(den_q[k]) << Sh;
    assign take  = (rem_q[k] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? (rem_q[k] - trial) : rem_q[k];
        quo_q[k+1] <= {quo_q[k][COORD_BITS-2:0], take};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        x0_q[k+1]  <= x0_q[k];
      end
    end
  end

  // Floor of the signed quotient, then the offset, then back toward zero.
  always_comb begin
    rem_nz = (rem_q[COORD_BITS] != '0);
    flo    = $signed({2'b00, quo_q[COORD_BITS]});
    if (neg_q[COORD_BITS]) begin
      flo = -flo - NUM_W'(rem_nz);
    end
    sum = flo + NUM_W'(x0_q[COORD_BITS]);
    if (rem_nz && (sum < 0)) begin
      sum = sum + NUM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= sum[COORD_BITS-1:0];
    end
  end

  assign res_o = res_q;

endmodule

### src/lwc_back.sv
// ----------------------------------------------------------------------------
// lwc_back
// Computes the four clipped coordinates of each queued segment and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module lwc_back import lwc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  lwc_job_t job_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lwc_out_t out_data_o
);

  logic                en;
  logic [LERP_LAT-1:0] v_q;
  logic [LERP_LAT-1:0] vis_q;
  logic                out_valid_q;
  lwc_out_t            out_q;
  coord_t              sx, sy, ex, ey;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !q_empty_i;

  lwc_lerp u_sx (.clk_i, .en_i(en), .x0_i(job_i.x0), .delta_i(job_i.dx),
                 .frac_i(job_i.u1), .res_o(sx));
  lwc_lerp u_sy (.clk_i, .en_i(en), .x0_i(job_i.y0), .delta_i(job_i.dy),
                 .frac_i(job_i.u1), .res_o(sy));
  lwc_lerp u_ex (.clk_i, .en_i(en), .x0_i(job_i.x0), .delta_i(job_i.dx),
                 .frac_i(job_i.u2), .res_o(ex));
  lwc_lerp u_ey (.clk_i, .en_i(en), .x0_i(job_i.y0), .delta_i(job_i.dy),
                 .frac_i(job_i.u2), .res_o(ey));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[LERP_LAT-2:0], !q_empty_i};
      out_valid_q <= v_q[LERP_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q <= {vis_q[LERP_LAT-2:0], job_i.vis};
      out_q.visible      <= vis_q[LERP_LAT-1];
      out_q.clip_start_x <= vis_q[LERP_LAT-1] ? sx : '0;
      out_q.clip_start_y <= vis_q[LERP_LAT-1] ? sy : '0;
      out_q.clip_end_x   <= vis_q[LERP_LAT-1] ? ex : '0;
      out_q.clip_end_y   <= vis_q[LERP_LAT-1] ? ey : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/line_window_clipper.sv
// ----------------------------------------------------------------------------
// line_window_clipper
// Clips line segments against a rectangular window held in registers.
// ----------------------------------------------------------------------------
// Segments enter on the in channel (valid/stall) and one result per segment
// leaves on the out channel (valid/stall) in the same order. The window
// edges are written through the APB port at byte addresses 0, 4, 8 and 12
// (left, bottom, right, top); the user must write them only while no
// segment is in flight, which the block itself does not enforce. One
// segment is taken per cycle unless the front stalls. A segment's result
// passes six front stages that form and compare the boundary ratios, the
// queue, eighteen interpolation stages (a multiply, sixteen restoring divide
// stages that settle one quotient bit each, a rounding stage), then the
// output register. When the receiver stalls, the back pipeline holds, the
// queue fills, and the front then stalls the sender. Reset empties all
// stages and the queue and clears the window to zero.
// ----------------------------------------------------------------------------
module line_window_clipper import lwc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lwc_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lwc_out_t           out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  lwc_win_t win_q;
  lwc_reg_e reg_idx;
  coord_t   rd_val;
  logic     wr_en;
  logic     push, pop, q_full, q_empty;
  lwc_job_t f_job, b_job;

  assign pready  = 1'b1;
  assign reg_idx = lwc_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegLeft:   win_q.left   <= pwdata[COORD_BITS-1:0];
        RegBottom: win_q.bottom <= pwdata[COORD_BITS-1:0];
        RegRight:  win_q.right  <= pwdata[COORD_BITS-1:0];
        RegTop:    win_q.top    <= pwdata[COORD_BITS-1:0];
        default:   win_q        <= win_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegLeft:   rd_val = win_q.left;
      RegBottom: rd_val = win_q.bottom;
      RegRight:  rd_val = win_q.right;
      RegTop:    rd_val = win_q.top;
      default:   rd_val = '0;
    endcase
  end

  assign prdata = {{(APB_DW-COORD_BITS){1'b0}}, rd_val};

  lwc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .win_i(win_q), .q_full_i(q_full), .push_o(push), .job_o(f_job)
  );

  lwc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(f_job), .pop_i(pop),
    .job_o(b_job), .full_o(q_full), .empty_o(q_empty)
  );

  lwc_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .job_i(b_job), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

### bench/line_window_clipper_test.sv
// ----------------------------------------------------------------------------
// line_window_clipper_test
// Checks the segment clipper against an exact rational clipping predictor.
// Segments are sent through a burst-driven request channel across several
// window settings, including extreme and inverted windows. Every result is
// compared field by field with the predicted clip, in order.
// ----------------------------------------------------------------------------
module line_window_clipper_test import lwc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lwc_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lwc_out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  line_window_clipper dut (.*);

  lwc_win_t window;
  lwc_in_t segment_q[$];
  lwc_out_t clip_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_long = 1'b0;
  bit pause_send = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sign of a/b - c/d with positive denominators, exact in 128 bits.
  function automatic int frac_cmp(longint a, longint b, longint c, longint d);
    logic signed [127:0] l, r;
    l = 128'(signed'(a)) * 128'(signed'(d));
    r = 128'(signed'(c)) * 128'(signed'(b));
    return (l > r) ? 1 : ((l < r) ? -1 : 0);
  endfunction

  function automatic coord_t interp(longint x0, longint delta, longint n, longint d);
    longint prod, fl, rm, v;
    prod = n * delta;
    fl = prod / d;
    rm = prod % d;
    // Division truncates toward zero, so step down to the floor when inexact and negative.
    if (rm != 0 && prod < 0) fl = fl - 1;
    v = x0 + fl;
    if (rm != 0 && v < 0) v = v + 1;
    return coord_t'(v);
  endfunction

  function automatic lwc_out_t clip_segment(lwc_in_t s, lwc_win_t w);
    lwc_out_t r;
    longint x1, y1, dx, dy, p[4], q[4], un, ud, vn, vd, n, d;
    bit ok;
    x1 = s.start_x; y1 = s.start_y;
    dx = longint'(s.end_x) - x1; dy = longint'(s.end_y) - y1;
    p[0] = -dx; q[0] = x1 - w.left;
    p[1] = dx;  q[1] = longint'(w.right) - x1;
    p[2] = -dy; q[2] = y1 - w.bottom;
    p[3] = dy;  q[3] = longint'(w.top) - y1;
    un = 0; ud = 1; vn = 1; vd = 1; ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (p[i] == 0) begin
        if (q[i] < 0) ok = 1'b0;
      end else begin
        n = p[i] < 0 ? -q[i] : q[i];
        d = p[i] < 0 ? -p[i] : p[i];
        if (p[i] < 0) begin
          if (frac_cmp(n, d, un, ud) > 0) begin un = n; ud = d; end
        end else if (frac_cmp(n, d, vn, vd) < 0) begin
          vn = n; vd = d;
        end
      end
    end
    if (ok && frac_cmp(un, ud, vn, vd) > 0) ok = 1'b0;
    r = '0;
    if (ok) begin
      r.visible = 1'b1;
      r.clip_start_x = interp(x1, dx, un, ud);
      r.clip_start_y = interp(y1, dy, un, ud);
      r.clip_end_x = interp(x1, dx, vn, vd);
      r.clip_end_y = interp(y1, dy, vn, vd);
    end
    return r;
  endfunction

  // Driver: bursts with random gaps; prediction happens on acceptance.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      clip_q.push_back(clip_segment(in_data_i, window));
      void'(segment_q.pop_front());
    end
    if ((in_valid_i && !in_stall_o) || !in_valid_i) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (segment_q.size() > 0 && !pause_send && rst_ni) begin
        in_valid_i <= 1'b1;
        in_data_i <= segment_q[0];
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk_i) begin
    lwc_out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (clip_q.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected result %p", $time, out_data_o);
      end else begin
        want = clip_q.pop_front();
        if (want.visible !== out_data_o.visible ||
            want.clip_start_x !== out_data_o.clip_start_x ||
            want.clip_start_y !== out_data_o.clip_start_y ||
            want.clip_end_x !== out_data_o.clip_end_x ||
            want.clip_end_y !== out_data_o.clip_end_y) begin
          errors <= errors + 1;
          $display("%0t: mismatch expected %p actual %p", $time, want, out_data_o);
        end
      end
    end
    if (hold_long) out_stall_i <= 1'b1;
    else if ((cycles / 200) % 3 == 0) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  task automatic write_reg(lwc_reg_e idx, coord_t value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx)); pwdata <= APB_DW'(signed'(value));
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegLeft:   window.left = value;
      RegBottom: window.bottom = value;
      RegRight:  window.right = value;
      RegTop:    window.top = value;
      default: ;
    endcase
  endtask

  task automatic set_window(coord_t l, coord_t b, coord_t r, coord_t t);
    write_reg(RegLeft, l); write_reg(RegBottom, b);
    write_reg(RegRight, r); write_reg(RegTop, t);
  endtask

  task automatic wait_idle();
    while (segment_q.size() > 0 || in_valid_i || clip_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic coord_t rnd_coord(coord_t lo, coord_t hi);
    return coord_t'($urandom_range(0, 3) == 0 ? $urandom :
                    int'(lo) + int'($urandom_range(0, int'(hi) - int'(lo))));
  endfunction

  task automatic add_seg(coord_t a, coord_t b, coord_t c, coord_t d);
    lwc_in_t s;
    s.start_x = a; s.start_y = b; s.end_x = c; s.end_y = d;
    segment_q.push_back(s);
  endtask

  task automatic random_phase(int count);
    coord_t lo, hi;
    lo = (window.left < window.bottom) ? window.left : window.bottom;
    hi = (window.right > window.top) ? window.right : window.top;
    if (lo > hi) begin lo = -100; hi = 100; end
    lo = (int'(lo) - 200 < -32768) ? coord_t'(-32768) : coord_t'(int'(lo) - 200);
    hi = (int'(hi) + 200 > 32767) ? coord_t'(32767) : coord_t'(int'(hi) + 200);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_seg(rnd_coord(lo, hi), rnd_coord(lo, hi), 0, 0);
        segment_q[$].end_x = segment_q[$].start_x;
        if ($urandom_range(0, 1)) segment_q[$].end_y = segment_q[$].start_y;
        else segment_q[$].end_y = rnd_coord(lo, hi);
      end else begin
        add_seg(rnd_coord(lo, hi), rnd_coord(lo, hi), rnd_coord(lo, hi), rnd_coord(lo, hi));
      end
    end
  endtask

  initial begin
    window = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset window (a single point), then a normal window.
    add_seg(0, 0, 0, 0);
    add_seg(-1, -1, 1, 1);
    add_seg(5, 5, 5, 5);
    wait_idle();
    set_window(-100, -50, 100, 50);
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(32767, 32767, -32768, -32768);
    add_seg(-32768, 0, 32767, 0);
    add_seg(0, -32768, 0, 32767);
    add_seg(-200, 0, -150, 0);        // parallel to an edge and outside
    add_seg(0, 0, 10, 10);            // wholly inside
    add_seg(-100, -50, 100, 50);      // along the diagonal corners
    add_seg(-100, -60, -100, 60);     // on the left edge
    add_seg(7, 7, 7, 7);              // single point inside
    add_seg(700, 7, 700, 7);          // single point outside
    add_seg(-300, 10, 300, -13);      // crosses both side edges
    add_seg(-150, -100, 150, 100);
    add_seg(200, 200, 300, 100);      // misses the corner
    wait_idle();
    set_window(100, 50, -100, -50);   // inverted
    add_seg(0, 0, 1, 1);
    add_seg(-32768, -32768, 32767, 32767);
    wait_idle();

    set_window(-32768, -32768, 32767, 32767);
    random_phase(150);
    wait_idle();

    set_window(-1000, -700, 1200, 900);
    random_phase(300);
    // Long receiver hold-off while requests keep coming.
    @(posedge clk_i);
    hold_long <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_long <= 1'b0;
    wait_idle();

    set_window(-3, 2, 4, 9);
    random_phase(250);
    // Sender pauses until everything outstanding has come back.
    while (segment_q.size() > 100) @(posedge clk_i);
    pause_send <= 1'b1;
    @(posedge clk_i);
    while (in_valid_i || clip_q.size() > 0) @(posedge clk_i);
    pause_send <= 1'b0;
    wait_idle();

    set_window(32767, 32767, 32767, 32767);
    random_phase(80);
    wait_idle();
    set_window(-20000, -30000, 30000, 20000);
    random_phase(400);
    wait_idle();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### line_window_clipper.f
+incdir+src
src/lwc_pkg.sv
src/lwc_front.sv
src/lwc_queue.sv
src/lwc_lerp.sv
src/lwc_back.sv
src/line_window_clipper.sv
bench/line_window_clipper_test.sv
